@@ rtl/frdr_pkg.sv @@
// Package for the fraction divide and reduce unit: shared types.
package frdr_pkg;

    // Divider command from the sequencer.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // Divider status back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/frdr_in_if.sv @@
// Input channel interface: numerator, denominator and divisor word.
interface frdr_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] numerator;
    logic signed [DATA_WIDTH-1:0] denominator;
    logic signed [DATA_WIDTH-1:0] divisor;

    modport source (output valid, numerator, denominator, divisor, input ready);
    modport sink   (input valid, numerator, denominator, divisor, output ready);
endinterface

@@ rtl/frdr_out_if.sv @@
// Output channel interface: scaled and reduced fraction word.
interface frdr_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [2*DATA_WIDTH-1:0] scaled_denominator;
    logic signed [DATA_WIDTH-1:0]   reduced_numerator;
    logic signed [2*DATA_WIDTH-1:0] reduced_denominator;
    logic                           zero_denominator;

    modport source (output valid, scaled_denominator, reduced_numerator,
                    reduced_denominator, zero_denominator, input ready);
    modport sink   (input valid, scaled_denominator, reduced_numerator,
                    reduced_denominator, zero_denominator, output ready);
endinterface

@@ rtl/fraction_divide_and_reduce_unit.sv @@
// Top level: fraction scaling, Euclid GCD and reduction on one shared divider.
//
//  channel | dir | word
//  i_in    | in  | numerator, denominator, divisor (DATA_WIDTH, signed)
//  o_out   | out | scaled_denominator, reduced_numerator, reduced_denominator,
//          |     | zero_denominator
//
// Steps: a multiply, then each Euclid step and each of the two final
//   divisions runs on the shared bit-serial divider (load, one shift step
//   per bit of the 2*DATA_WIDTH-bit quotient, done). A zero scaled
//   denominator skips the divider and goes straight to the output.
// One word in flight; i_in.ready is high only while the sequencer is idle.
// A finished word waits in the output register, so the next word may enter.
// Reset (synchronous, active low) clears the sequencer and output valid.
module fraction_divide_and_reduce_unit #(
    parameter int DATA_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frdr_in_if.sink     i_in,
    frdr_out_if.source  o_out
);
    localparam int W  = DATA_WIDTH;
    localparam int W2 = 2 * DATA_WIDTH;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_GCD   = 9'b000000100,
        S_GWAIT = 9'b000001000,
        S_DIVN  = 9'b000010000,
        S_NWAIT = 9'b000100000,
        S_DIVS  = 9'b001000000,
        S_SWAIT = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;

    // operand magnitudes and signs
    logic [W-1:0]  r_n_mag, r_d_mag, r_v_mag;
    logic          r_n_neg, r_s_neg;
    logic [W2-1:0] r_s_mag;
    // Euclid pair and result
    logic [W2-1:0] r_a, r_b, r_g;
    logic [W-1:0]  r_qn;
    logic [W2-1:0] r_qs;
    logic          r_zero;

    // output register
    logic          r_o_valid;
    logic [W2-1:0] r_o_scaled, r_o_rden;
    logic [W-1:0]  r_o_rnum;
    logic          r_o_zero;

    logic [W-1:0]  n_raw, d_raw, v_raw;
    logic [W-1:0]  n_n_mag, n_d_mag, n_v_mag;

    frdr_pkg::t_div_ctl  div_ctl;
    frdr_pkg::t_div_stat div_stat;
    logic [W2-1:0]       div_dividend, div_divisor, div_quo, div_rem;
    logic                out_load;

    assign n_raw   = i_in.numerator;
    assign d_raw   = i_in.denominator;
    assign v_raw   = i_in.divisor;
    assign n_n_mag = n_raw[W-1] ? (~n_raw + 1'b1) : n_raw;
    assign n_d_mag = d_raw[W-1] ? (~d_raw + 1'b1) : d_raw;
    assign n_v_mag = v_raw[W-1] ? (~v_raw + 1'b1) : v_raw;

    assign i_in.ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_OUT) && (!r_o_valid || o_out.ready);

    // divider command and operand select
    always_comb begin
        div_ctl.start = 1'b0;
        div_dividend  = r_a;
        div_divisor   = r_b;
        unique case (r_state)
            S_GCD: begin
                div_ctl.start = (r_b != '0);
            end
            S_DIVN: begin
                div_ctl.start = 1'b1;
                div_dividend  = W2'(r_n_mag);
                div_divisor   = r_g;
            end
            S_DIVS: begin
                div_ctl.start = 1'b1;
                div_dividend  = r_s_mag;
                div_divisor   = r_g;
            end
            default: begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    frdr_divider #(.WIDTH(W2)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_n_mag <= n_n_mag;
                        r_d_mag <= n_d_mag;
                        r_v_mag <= n_v_mag;
                        r_n_neg <= n_raw[W-1];
                        r_s_neg <= d_raw[W-1] ^ v_raw[W-1];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_s_mag <= W2'(r_d_mag) * W2'(r_v_mag);
                    r_b     <= W2'(r_d_mag) * W2'(r_v_mag);
                    r_a     <= W2'(r_n_mag);
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    if (r_b != '0) begin
                        r_state <= S_GWAIT;
                    end else if (r_s_mag == '0) begin
                        // zero scaled denominator: flag, no reduction
                        r_zero  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_zero  <= 1'b0;
                        r_g     <= r_a;
                        r_state <= S_DIVN;
                    end
                end
                S_GWAIT: begin
                    if (div_stat.done) begin
                        r_a     <= r_b;
                        r_b     <= div_rem;
                        r_state <= S_GCD;
                    end
                end
                S_DIVN: begin
                    r_state <= S_NWAIT;
                end
                S_NWAIT: begin
                    if (div_stat.done) begin
                        r_qn    <= div_quo[W-1:0];
                        r_state <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    r_state <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (div_stat.done) begin
                        r_qs    <= div_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register, signs reapplied here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_zero <= r_zero;
            if (r_zero) begin
                r_o_scaled <= '0;
                r_o_rnum   <= '0;
                r_o_rden   <= '0;
            end else begin
                r_o_scaled <= r_s_neg ? (~r_s_mag + 1'b1) : r_s_mag;
                r_o_rnum   <= r_n_neg ? (~r_qn + 1'b1) : r_qn;
                r_o_rden   <= r_s_neg ? (~r_qs + 1'b1) : r_qs;
            end
        end
    end

    assign o_out.valid               = r_o_valid;
    assign o_out.scaled_denominator  = r_o_scaled;
    assign o_out.reduced_numerator   = r_o_rnum;
    assign o_out.reduced_denominator = r_o_rden;
    assign o_out.zero_denominator    = r_o_zero;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_GWAIT || r_state == S_NWAIT ||
                           r_state == S_SWAIT))
        else $error("divider finished outside a wait state");

    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_MUL))
        else $error("accepted word did not enter multiply");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_zero) |-> (r_o_scaled == '0 && r_o_rnum == '0 &&
                                     r_o_rden == '0))
        else $error("zero denominator word has nonzero fields");
`endif
endmodule

@@ rtl/frdr_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
module frdr_divider #(
    parameter int WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  frdr_pkg::t_div_ctl    i_ctl,
    input  logic [WIDTH-1:0]      i_dividend,
    input  logic [WIDTH-1:0]      i_divisor,
    output frdr_pkg::t_div_stat   o_stat,
    output logic [WIDTH-1:0]      o_quotient,
    output logic [WIDTH-1:0]      o_remainder
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH:0]   r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_div;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   trial;
    logic             fits;

    assign trial = {r_rem[WIDTH-1:0], r_quo[WIDTH-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_cnt  <= CW'(WIDTH);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
                r_quo <= {r_quo[WIDTH-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[WIDTH-1:0];
endmodule
